### src/bup4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup4_pkg
// Shared sizes and the job word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package bup4_pkg;

	localparam int SRC_SIZE = 256;
	localparam int DST_SIZE = 1024;

	localparam int RW = $clog2(SRC_SIZE);       // source coordinate width
	localparam int CW = $clog2(4 * SRC_SIZE);   // output coordinate width

	localparam int SAMPLE_W = 16;
	localparam int COORD_W  = 10;
	localparam int VALUE_W  = 22;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// One classified source pixel with its three neighbors (up, left, upper-left)
	typedef struct packed {
		logic [RW-1:0]              row;
		logic [RW-1:0]              col;
		logic signed [SAMPLE_W-1:0] cur;
		logic signed [SAMPLE_W-1:0] up;
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] upleft;
	} job_t;

endpackage

### src/bup4_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup4_in_if / bup4_out_if
// Valid/ready channels for source samples and interpolated results.
// ----------------------------------------------------------------------------
interface bup4_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface bup4_out_if;
	logic               valid;
	logic               ready;
	logic [9:0]         out_row;
	logic [9:0]         out_col;
	logic signed [21:0] out_value;
	logic               last_of_run;

	modport source (output valid, output out_row, output out_col, output out_value,
		output last_of_run, input ready);
	modport sink (input valid, input out_row, input out_col, input out_value,
		input last_of_run, output ready);
endinterface

### src/bilinear_upsample_x4_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_upsample_x4_top
// 4x bilinear upscaler with half-pixel centers for a streamed square image.
// ----------------------------------------------------------------------------
// Usage:
//  - pixels: one signed 16-bit source word per handshake, raster order,
//    SRC_SIZE x SRC_SIZE per frame; the position wraps to (0,0) after the
//    last word of a frame.
//  - results: one output pixel per handshake (row, column, value times 64),
//    grouped by the source word that completes it, raster order within a
//    group; last_of_run marks the final word of each group.
//  - A group holds 16 words as a rule, 4 to 36 at the borders. The result
//    side delivers one word per cycle while the receiver is ready, so a
//    source word holds the back end until its group is out: 16 on average.
//  - An accepted source word reaches its first result through the input
//    register, job queue, sequencer, then three pipeline stages (neighbor
//    select, horizontal blend, vertical blend).
//  - A four-entry job queue parts the two sides: source words keep being
//    taken while the receiver stalls, until the queue fills.
//  - Reset clears the position, the left/upper-left neighbors and all
//    valid state; the line buffer is not cleared (row 0 never uses it).
// ----------------------------------------------------------------------------
module bilinear_upsample_x4_top
	import bup4_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	bup4_in_if.sink    pixels,
	bup4_out_if.source results
);

	logic push, full, pop, empty;
	job_t wr_job, head;

	bup4_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels),
		.push   (push),
		.job    (wr_job),
		.full   (full)
	);

	bup4_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.head   (head),
		.empty  (empty)
	);

	bup4_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.results (results)
	);

endmodule

### src/bup4_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup4_front
// Accepts source words, tracks raster position, keeps the line buffer and
// gathers each pixel and its three neighbors (up, left, upper-left) into a job word.
// ----------------------------------------------------------------------------
module bup4_front
	import bup4_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bup4_in_if.sink     pixels,
	output logic        push,
	output job_t        job,
	input  logic        full
);

	logic signed [SAMPLE_W-1:0] line_mem [SRC_SIZE];

	logic [RW-1:0]              src_row_q, src_col_q;
	logic signed [SAMPLE_W-1:0] left_q, upleft_q;

	logic                       vld_s1;
	logic [RW-1:0]              row_s1, col_s1;
	logic signed [SAMPLE_W-1:0] cur_s1, left_s1, up_s1;

	logic accept;

	assign push         = vld_s1 & ~full;
	assign pixels.ready = ~vld_s1 | push;
	assign accept       = pixels.valid & pixels.ready;

	assign job.row    = row_s1;
	assign job.col    = col_s1;
	assign job.cur    = cur_s1;
	assign job.up     = up_s1;
	assign job.left   = left_s1;
	assign job.upleft = upleft_q;

	// Read before write: the word above comes out as the new one goes in
	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1                <= line_mem[src_col_q];
			line_mem[src_col_q]  <= pixels.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_row_q <= '0;
			src_col_q <= '0;
			left_q    <= '0;
			upleft_q  <= '0;
			vld_s1    <= 1'b0;
			row_s1    <= '0;
			col_s1    <= '0;
			cur_s1    <= '0;
			left_s1   <= '0;
		end else begin
			if (push)
				upleft_q <= up_s1;
			if (accept) begin
				vld_s1  <= 1'b1;
				row_s1  <= src_row_q;
				col_s1  <= src_col_q;
				cur_s1  <= pixels.sample;
				left_s1 <= left_q;
				left_q  <= pixels.sample;
				if (src_col_q == RW'(SRC_SIZE - 1)) begin
					src_col_q <= '0;
					src_row_q <= (src_row_q == RW'(SRC_SIZE - 1)) ? '0 : src_row_q + 1'b1;
				end else begin
					src_col_q <= src_col_q + 1'b1;
				end
			end else if (push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

endmodule

### src/bup4_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup4_queue
// Short FIFO of job words between the front end and the back end.
// ----------------------------------------------------------------------------
module bup4_queue
	import bup4_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic empty
);

	job_t           entries [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entries[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### src/bup4_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup4_back
// Walks the output pixels of each job in raster order and interpolates them
// through a three-stage pipeline (select, horizontal blend, vertical blend).
// ----------------------------------------------------------------------------
module bup4_back
	import bup4_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  logic      empty,
	output logic      pop,
	bup4_out_if.source results
);

	localparam int LIM = (DST_SIZE < 4 * SRC_SIZE) ? DST_SIZE : 4 * SRC_SIZE;
	localparam int TW  = CW + 2;

	// floor((2p-3)/8) as a signed base
	function automatic logic signed [TW-1:0] base_of(input logic [CW-1:0] p);
		logic signed [TW-1:0] t;
		t = $signed({1'b0, p, 1'b0}) - TW'(3);
		return t >>> 3;
	endfunction

	function automatic logic [2:0] frac_of(input logic [CW-1:0] p);
		logic [TW-1:0] t;
		t = {1'b0, p, 1'b0} - TW'(3);
		return t[2:0];
	endfunction

	function automatic logic [RW-1:0] clamp_src(input logic signed [TW-1:0] i);
		if (i < 0)
			return '0;
		if (i > TW'(SRC_SIZE - 1))
			return RW'(SRC_SIZE - 1);
		return i[RW-1:0];
	endfunction

	function automatic logic [CW-1:0] lo_of(input logic [RW-1:0] s);
		if (s == '0)
			return '0;
		return {s, 2'b00} - CW'(2);
	endfunction

	function automatic logic [CW-1:0] hi_of(input logic [RW-1:0] s);
		logic [CW-1:0] h;
		h = (s == RW'(SRC_SIZE - 1)) ? {s, 2'b11} : {s, 2'b01};
		return (h > CW'(LIM - 1)) ? CW'(LIM - 1) : h;
	endfunction

	// sequencer
	logic          active_q;
	job_t          job_q;
	logic [CW-1:0] y_q, x_q, xlo_q, xhi_q, yhi_q;

	logic          adv, at_end, want;
	logic [CW-1:0] ylo_n, yhi_n, xlo_n, xhi_n;
	logic          empty_n;

	// pipeline
	logic                       vld_s1, vld_s2, vld_s3;
	logic                       last_s1, last_s2, last_s3;
	logic [CW-1:0]              y_s1, x_s1, y_s2, x_s2, y_s3, x_s3;
	logic signed [SAMPLE_W-1:0] g00_s1, g01_s1, g10_s1, g11_s1;
	logic [2:0]                 ax_s1, ay_s1, ay_s2;
	logic signed [19:0]         h0_s2, h1_s2;
	logic signed [VALUE_W-1:0]  v_s3;

	logic [RW-1:0]              r0, r1, c0, c1;
	logic                       r0_cur, r1_cur, c0_cur, c1_cur;
	logic signed [SAMPLE_W-1:0] g00, g01, g10, g11;
	logic signed [20:0]         h0_n, h1_n;
	logic signed [24:0]         v_n;

	assign adv    = ~vld_s3 | results.ready;
	assign at_end = (x_q == xhi_q) && (y_q == yhi_q);
	assign want   = adv & (~active_q | at_end);
	assign pop    = want & ~empty;

	assign ylo_n   = lo_of(head.row);
	assign yhi_n   = hi_of(head.row);
	assign xlo_n   = lo_of(head.col);
	assign xhi_n   = hi_of(head.col);
	// clipped away entirely when the output frame is smaller
	assign empty_n = (ylo_n > yhi_n) || (xlo_n > xhi_n);

	always_comb begin
		r0 = clamp_src(base_of(y_q));
		r1 = clamp_src(base_of(y_q) + TW'(1));
		c0 = clamp_src(base_of(x_q));
		c1 = clamp_src(base_of(x_q) + TW'(1));
		r0_cur = (r0 == job_q.row);
		r1_cur = (r1 == job_q.row);
		c0_cur = (c0 == job_q.col);
		c1_cur = (c1 == job_q.col);
		g00 = r0_cur ? (c0_cur ? job_q.cur : job_q.left) : (c0_cur ? job_q.up : job_q.upleft);
		g01 = r0_cur ? (c1_cur ? job_q.cur : job_q.left) : (c1_cur ? job_q.up : job_q.upleft);
		g10 = r1_cur ? (c0_cur ? job_q.cur : job_q.left) : (c0_cur ? job_q.up : job_q.upleft);
		g11 = r1_cur ? (c1_cur ? job_q.cur : job_q.left) : (c1_cur ? job_q.up : job_q.upleft);
	end

	// weights are in eighths: (8 - a) and a
	always_comb begin
		h0_n = 21'(g00_s1 * $signed({1'b0, 3'(4'd8 - {1'b0, ax_s1})}))
			+ 21'(g01_s1 * $signed({1'b0, ax_s1}));
		h1_n = 21'(g10_s1 * $signed({1'b0, 3'(4'd8 - {1'b0, ax_s1})}))
			+ 21'(g11_s1 * $signed({1'b0, ax_s1}));
		v_n  = 25'(h0_s2 * $signed({1'b0, 3'(4'd8 - {1'b0, ay_s2})}))
			+ 25'(h1_s2 * $signed({1'b0, ay_s2}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			job_q    <= '0;
			y_q      <= '0;
			x_q      <= '0;
			xlo_q    <= '0;
			xhi_q    <= '0;
			yhi_q    <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			last_s1  <= 1'b0;
			last_s2  <= 1'b0;
			last_s3  <= 1'b0;
			y_s1     <= '0;
			x_s1     <= '0;
			y_s2     <= '0;
			x_s2     <= '0;
			y_s3     <= '0;
			x_s3     <= '0;
			g00_s1   <= '0;
			g01_s1   <= '0;
			g10_s1   <= '0;
			g11_s1   <= '0;
			ax_s1    <= '0;
			ay_s1    <= '0;
			ay_s2    <= '0;
			h0_s2    <= '0;
			h1_s2    <= '0;
			v_s3     <= '0;
		end else if (adv) begin
			if (active_q && !at_end) begin
				if (x_q == xhi_q) begin
					x_q <= xlo_q;
					y_q <= y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			if (want) begin
				if (!empty) begin
					job_q    <= head;
					y_q      <= ylo_n;
					x_q      <= xlo_n;
					xlo_q    <= xlo_n;
					xhi_q    <= xhi_n;
					yhi_q    <= yhi_n;
					active_q <= ~empty_n;
				end else begin
					active_q <= 1'b0;
				end
			end

			vld_s1  <= active_q;
			last_s1 <= at_end;
			y_s1    <= y_q;
			x_s1    <= x_q;
			g00_s1  <= g00;
			g01_s1  <= g01;
			g10_s1  <= g10;
			g11_s1  <= g11;
			ax_s1   <= frac_of(x_q);
			ay_s1   <= frac_of(y_q);

			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			y_s2    <= y_s1;
			x_s2    <= x_s1;
			ay_s2   <= ay_s1;
			h0_s2   <= h0_n[19:0];
			h1_s2   <= h1_n[19:0];

			vld_s3  <= vld_s2;
			last_s3 <= last_s2;
			y_s3    <= y_s2;
			x_s3    <= x_s2;
			v_s3    <= v_n[VALUE_W-1:0];
		end
	end

	assign results.valid       = vld_s3;
	assign results.out_row     = COORD_W'(y_s3);
	assign results.out_col     = COORD_W'(x_s3);
	assign results.out_value   = v_s3;
	assign results.last_of_run = last_s3;

endmodule
